// File: rtl/core/bdsp_pkg.sv
// bdsp_pkg: shared types and codes of the blocked degree sort permutation block
// no dependencies; used by every file under rtl/core
`default_nettype none
package bdsp_pkg;

	localparam int unsigned ENTRY_W = 10;
	localparam int unsigned INDEX_W = 32;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_NO_BUILD = 2'd2;

	localparam logic [1:0] REG_DIM   = 2'd0;
	localparam logic [1:0] REG_ROW   = 2'd1;
	localparam logic [1:0] REG_FIRST = 2'd2;
	localparam logic [1:0] REG_SORT  = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [INDEX_W-1:0] row_index;
		logic [INDEX_W-1:0] column_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ENTRY_W-1:0] perm_entry;
		logic [ENTRY_W-1:0] inverse_entry;
	} result_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} chain_ctrl_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD,
		S_RD,
		S_FEED,
		S_FLUSH,
		S_DRAIN,
		S_IDENT,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

// File: rtl/core/bdsp_cell.sv
// bdsp_cell: one sorting cell, keeps the smaller key and passes the larger on
// depends on bdsp_pkg
`default_nettype none
module bdsp_cell #(
	parameter int unsigned KW = 8
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  bdsp_pkg::chain_ctrl_t    ctrl,
	input  wire                      in_v,
	input  wire [KW-1:0]             in_key,
	input  wire                      next_v,
	input  wire [KW-1:0]             next_key,
	output logic                     held_v,
	output logic [KW-1:0]            held_key,
	output logic                     pass_v,
	output logic [KW-1:0]            pass_key
);

	logic          held_v_q, pass_v_q;
	logic [KW-1:0] held_key_q, pass_key_q;
	logic          take;

	assign take = in_v && (!held_v_q || (in_key < held_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			pass_v_q <= 1'b0;
		end else if (ctrl.drain) begin
			held_v_q <= next_v;
			pass_v_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (take) begin
				held_v_q <= 1'b1;
				pass_v_q <= held_v_q;
			end else begin
				pass_v_q <= in_v;
			end
		end else begin
			pass_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			held_key_q <= next_key;
		end else if (ctrl.insert) begin
			if (take) begin
				held_key_q <= in_key;
				pass_key_q <= held_key_q;
			end else begin
				pass_key_q <= in_key;
			end
		end
	end

	assign held_v   = held_v_q;
	assign held_key = held_key_q;
	assign pass_v   = pass_v_q;
	assign pass_key = pass_key_q;

endmodule
`default_nettype wire

// File: rtl/core/bdsp_chain.sv
// bdsp_chain: row of sorting cells, smallest key ends up at the head
// depends on bdsp_pkg and bdsp_cell
`default_nettype none
module bdsp_chain #(
	parameter int unsigned CELLS = 4,
	parameter int unsigned KW    = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  bdsp_pkg::chain_ctrl_t ctrl,
	input  wire                   in_v,
	input  wire [KW-1:0]          in_key,
	output logic                  head_v,
	output logic [KW-1:0]         head_key
);

	logic [CELLS:0]        lv;
	logic [KW-1:0]         lkey [CELLS+1];
	logic [CELLS:0]        hv;
	logic [KW-1:0]         hkey [CELLS+1];

	assign lv[0]       = in_v;
	assign lkey[0]     = in_key;
	// empty entry shifted in behind the last cell while draining
	assign hv[CELLS]   = 1'b0;
	assign hkey[CELLS] = '0;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		bdsp_cell #(.KW(KW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.in_v     (lv[k]),
			.in_key   (lkey[k]),
			.next_v   (hv[k+1]),
			.next_key (hkey[k+1]),
			.held_v   (hv[k]),
			.held_key (hkey[k]),
			.pass_v   (lv[k+1]),
			.pass_key (lkey[k+1])
		);
	end

	assign head_v   = hv[0];
	assign head_key = hkey[0];

endmodule
`default_nettype wire

// File: rtl/core/blocked_degree_sort_permutation.sv
// channel  | handshake            | payload
// cmd      | start / busy         | bdsp_pkg::cmd_t (opcode, row_index, column_index)
// result   | done (one cycle)     | bdsp_pkg::result_t (status, perm_entry, inverse_entry)
// config   | apb psel/penable     | dim_count, row_mode, use_first_nonzero, sort_enable
// after reset a clearing pass over all MAX_ENTRIES entries runs with busy high
// add and read: count/table memory read, then memory write or result
// clear writes all MAX_ENTRIES entries; build runs per block a feed, a flush
// and a drain phase through the cell chain, or an identity pass over n entries with sorting off
// the result beat follows the last busy cycle; the receiver cannot stall it
// top level: holds control, count and table memories; depends on bdsp_pkg, bdsp_chain
`default_nettype none
module blocked_degree_sort_permutation #(
	parameter int unsigned MAX_ENTRIES = 1024,
	parameter int unsigned SORT_BLOCK  = 256,
	parameter int unsigned COUNT_BITS  = 20
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  bdsp_pkg::cmd_t          cmd,
	output logic                    done,
	output bdsp_pkg::result_t       result,
	input  wire                     psel,
	input  wire                     penable,
	input  wire                     pwrite,
	input  wire  [3:0]              paddr,
	input  wire  [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int unsigned AW = $clog2(MAX_ENTRIES);
	localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CW = $clog2(SORT_BLOCK + 1);
	localparam int unsigned KW = COUNT_BITS + bdsp_pkg::INDEX_W + AW;

	// configuration
	logic [10:0] dim_count_q;
	logic        row_mode_q, first_q, sort_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= 11'd1024;
			row_mode_q  <= 1'b1;
			first_q     <= 1'b0;
			sort_en_q   <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				bdsp_pkg::REG_DIM:   dim_count_q <= pwdata[10:0];
				bdsp_pkg::REG_ROW:   row_mode_q  <= pwdata[0];
				bdsp_pkg::REG_FIRST: first_q     <= pwdata[0];
				bdsp_pkg::REG_SORT:  sort_en_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bdsp_pkg::REG_DIM:   prdata = {21'd0, dim_count_q};
			bdsp_pkg::REG_ROW:   prdata = {31'd0, row_mode_q};
			bdsp_pkg::REG_FIRST: prdata = {31'd0, first_q};
			bdsp_pkg::REG_SORT:  prdata = {31'd0, sort_en_q};
			default:             prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	logic [NW-1:0] n_w;
	assign n_w = (32'(dim_count_q) > 32'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(dim_count_q);

	// state
	bdsp_pkg::state_t state_q, state_d;
	logic [NW-1:0]    idx_q, base_q, bn_q, built_n_q;
	logic [CW-1:0]    cnt_q;
	logic             built_q, clr_op_q, oor_q;
	logic [AW-1:0]    major_q;
	logic [31:0]      minor_q;
	logic [1:0]       rd_status_q;
	logic             done_q, done_d;
	bdsp_pkg::result_t res_q, res_d;
	logic             feed_v_s1;
	logic [AW-1:0]    feed_idx_s1;

	// memories
	logic [COUNT_BITS-1:0] cnt_mem [MAX_ENTRIES];
	logic [31:0]           min_mem [MAX_ENTRIES];
	logic [AW-1:0]         ord_mem [MAX_ENTRIES];
	logic [AW-1:0]         inv_mem [MAX_ENTRIES];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [31:0]           min_rd_q;
	logic [AW-1:0]         ord_rd_q, inv_rd_q;

	logic accept;
	assign accept = start && (state_q == bdsp_pkg::S_IDLE);

	logic [31:0] major_w, minor_w;
	assign major_w = row_mode_q ? cmd.row_index : cmd.column_index;
	assign minor_w = row_mode_q ? cmd.column_index : cmd.row_index;

	logic [NW-1:0] rem_w;
	logic [CW-1:0] blen_w;
	assign rem_w  = bn_q - base_q;
	assign blen_w = (32'(rem_w) > 32'(SORT_BLOCK)) ? CW'(SORT_BLOCK) : CW'(rem_w);

	logic          cnt_last;
	logic [NW-1:0] base_next;
	assign cnt_last  = (32'(cnt_q) + 32'd1) == 32'(blen_w);
	assign base_next = base_q + NW'(blen_w);

	logic          head_v;
	logic [KW-1:0] head_key;
	logic [AW-1:0] head_idx;
	assign head_idx = head_key[AW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bdsp_pkg::S_CLEAR:
				if (32'(idx_q) == 32'(MAX_ENTRIES - 1)) state_d = bdsp_pkg::S_IDLE;
			bdsp_pkg::S_IDLE:
				if (accept) begin
					case (cmd.opcode)
						bdsp_pkg::OP_ADD:   state_d = bdsp_pkg::S_ADD;
						bdsp_pkg::OP_READ:  state_d = bdsp_pkg::S_RD;
						bdsp_pkg::OP_CLEAR: state_d = bdsp_pkg::S_CLEAR;
						default: begin
							if (n_w == '0)      state_d = bdsp_pkg::S_FIN;
							else if (sort_en_q) state_d = bdsp_pkg::S_FEED;
							else                state_d = bdsp_pkg::S_IDENT;
						end
					endcase
				end
			bdsp_pkg::S_ADD, bdsp_pkg::S_RD, bdsp_pkg::S_FIN:
				state_d = bdsp_pkg::S_IDLE;
			bdsp_pkg::S_FEED:
				if (cnt_last) state_d = bdsp_pkg::S_FLUSH;
			bdsp_pkg::S_FLUSH:
				if (32'(cnt_q) == 32'(SORT_BLOCK)) state_d = bdsp_pkg::S_DRAIN;
			bdsp_pkg::S_DRAIN:
				if (cnt_last)
					state_d = (base_next >= bn_q) ? bdsp_pkg::S_FIN : bdsp_pkg::S_FEED;
			bdsp_pkg::S_IDENT:
				if (idx_q + NW'(1) == bn_q) state_d = bdsp_pkg::S_FIN;
			default: state_d = bdsp_pkg::S_IDLE;
		endcase
	end

	// outputs and memory control
	bdsp_pkg::chain_ctrl_t ctrl;
	logic          cm_we, om_we;
	logic [AW-1:0] cm_wa, om_wa, im_wa, om_wd, im_wd, cm_ra;
	logic [COUNT_BITS-1:0] cm_wd;
	logic [31:0]   mm_wd;

	always_comb begin
		ctrl.insert = (state_q == bdsp_pkg::S_FEED) || (state_q == bdsp_pkg::S_FLUSH);
		ctrl.drain  = (state_q == bdsp_pkg::S_DRAIN);
		busy        = (state_q != bdsp_pkg::S_IDLE);
		cm_we = 1'b0;
		cm_wa = major_q;
		cm_wd = (cnt_rd_q == {COUNT_BITS{1'b1}}) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);
		mm_wd = (minor_q < min_rd_q) ? minor_q : min_rd_q;
		cm_ra = (state_q == bdsp_pkg::S_FEED) ? AW'(32'(base_q) + 32'(cnt_q)) : major_w[AW-1:0];
		om_we = 1'b0;
		om_wa = AW'(idx_q);
		om_wd = AW'(idx_q);
		im_wa = AW'(idx_q);
		im_wd = AW'(idx_q);
		case (state_q)
			bdsp_pkg::S_CLEAR: begin
				cm_we = 1'b1;
				cm_wa = AW'(idx_q);
				cm_wd = '0;
				mm_wd = '1;
			end
			bdsp_pkg::S_ADD: cm_we = !oor_q;
			bdsp_pkg::S_IDENT: om_we = 1'b1;
			bdsp_pkg::S_DRAIN: begin
				om_we = 1'b1;
				om_wa = AW'(32'(base_q) + 32'(cnt_q));
				om_wd = head_idx;
				im_wa = head_idx;
				im_wd = om_wa;
			end
			default: ;
		endcase
	end

	// result beat and its payload
	always_comb begin
		done_d = 1'b0;
		res_d  = '0;
		case (state_q)
			bdsp_pkg::S_CLEAR: done_d = clr_op_q && (state_d == bdsp_pkg::S_IDLE);
			bdsp_pkg::S_ADD: begin
				done_d = 1'b1;
				if (oor_q) res_d.status = bdsp_pkg::ST_RANGE;
			end
			bdsp_pkg::S_RD: begin
				done_d       = 1'b1;
				res_d.status = rd_status_q;
				if (rd_status_q == bdsp_pkg::ST_OK) begin
					res_d.perm_entry    = bdsp_pkg::ENTRY_W'(ord_rd_q);
					res_d.inverse_entry = bdsp_pkg::ENTRY_W'(inv_rd_q);
				end
			end
			bdsp_pkg::S_FIN: done_d = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cnt_mem[cm_wa] <= cm_wd;
			min_mem[cm_wa] <= mm_wd;
		end
		cnt_rd_q <= cnt_mem[cm_ra];
		min_rd_q <= min_mem[cm_ra];
	end

	always_ff @(posedge clk) begin
		if (om_we) begin
			ord_mem[om_wa] <= om_wd;
			inv_mem[im_wa] <= im_wd;
		end
		ord_rd_q <= ord_mem[cmd.row_index[AW-1:0]];
		inv_rd_q <= inv_mem[cmd.row_index[AW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bdsp_pkg::S_CLEAR;
			idx_q     <= '0;
			base_q    <= '0;
			cnt_q     <= '0;
			bn_q      <= '0;
			built_q   <= 1'b0;
			built_n_q <= '0;
			clr_op_q  <= 1'b0;
			done_q    <= 1'b0;
			feed_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= done_d;
			feed_v_s1 <= (state_q == bdsp_pkg::S_FEED);
			case (state_q)
				bdsp_pkg::S_CLEAR: idx_q <= idx_q + NW'(1);
				bdsp_pkg::S_IDLE:
					if (accept) begin
						idx_q    <= '0;
						base_q   <= '0;
						cnt_q    <= '0;
						bn_q     <= n_w;
						clr_op_q <= 1'b1;
					end
				bdsp_pkg::S_FEED: cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
				bdsp_pkg::S_FLUSH:
					cnt_q <= (32'(cnt_q) == 32'(SORT_BLOCK)) ? '0 : cnt_q + CW'(1);
				bdsp_pkg::S_DRAIN: begin
					cnt_q <= cnt_last ? '0 : cnt_q + CW'(1);
					if (cnt_last) base_q <= base_next;
				end
				bdsp_pkg::S_IDENT: idx_q <= idx_q + NW'(1);
				bdsp_pkg::S_FIN: begin
					built_q   <= 1'b1;
					built_n_q <= bn_q;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		feed_idx_s1 <= AW'(32'(base_q) + 32'(cnt_q));
		if (accept) begin
			major_q <= major_w[AW-1:0];
			minor_q <= minor_w;
			oor_q   <= major_w >= 32'(n_w);
			if (!built_q)                         rd_status_q <= bdsp_pkg::ST_NO_BUILD;
			else if (cmd.row_index >= 32'(built_n_q)) rd_status_q <= bdsp_pkg::ST_RANGE;
			else                                  rd_status_q <= bdsp_pkg::ST_OK;
		end
		res_q <= res_d;
	end

	assign done   = done_q;
	assign result = res_q;

	// key: count, then least minor index when enabled, then original index
	logic [KW-1:0] feed_key;
	assign feed_key = {cnt_rd_q, first_q ? min_rd_q : 32'd0, feed_idx_s1};

	bdsp_chain #(.CELLS(SORT_BLOCK), .KW(KW)) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.in_v     (feed_v_s1),
		.in_key   (feed_key),
		.head_v   (head_v),
		.head_key (head_key)
	);

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result beat without preceding work");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted command did not start");
	a_drain_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdsp_pkg::S_DRAIN) |-> head_v) else $error("chain head empty in drain");
`endif

endmodule
`default_nettype wire

// File: tb/tb_blocked_degree_sort_permutation.sv
// tb_blocked_degree_sort_permutation: self-checking bench for the degree sort permutation block
// depends on bdsp_pkg and blocked_degree_sort_permutation; predicts results with its own model
`default_nettype none
module tb_blocked_degree_sort_permutation;

	localparam int unsigned N_MAX = 1024;
	localparam int unsigned BLK = 256;
	localparam logic [19:0] CNT_SAT = 20'hFFFFF;
	localparam int unsigned STALL_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, pready;
	bdsp_pkg::cmd_t cmd = '0;
	bdsp_pkg::result_t result;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;

	blocked_degree_sort_permutation dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [10:0] m_dim;
	logic m_row, m_first, m_sort;
	logic [19:0] m_cnt [N_MAX];
	logic [31:0] m_least [N_MAX];
	logic [9:0] m_order [N_MAX];
	logic [9:0] m_inv [N_MAX];
	logic m_built;
	int unsigned m_built_n;

	bdsp_pkg::cmd_t cmd_queue[$];
	bdsp_pkg::result_t result_queue[$];
	int errors = 0;
	int idle_pct = 6;
	bit driver_hold = 1'b0;
	int quiet_cycles = 0;
	logic busy_at_edge = 1'b0;

	function automatic int unsigned active_n();
		return (32'(m_dim) > N_MAX) ? N_MAX : 32'(m_dim);
	endfunction

	function automatic bit ranks_lower(int unsigned a, int unsigned b);
		if (m_cnt[a] != m_cnt[b]) return m_cnt[a] < m_cnt[b];
		if (m_first && m_least[a] != m_least[b]) return m_least[a] < m_least[b];
		return a < b;
	endfunction

	function automatic void wipe_counts();
		for (int i = 0; i < N_MAX; i++) begin
			m_cnt[i] = '0;
			m_least[i] = '1;
		end
	endfunction

	function automatic void build_order();
		int unsigned n, len, j;
		logic [9:0] v;
		n = active_n();
		for (int i = 0; i < n; i++) m_order[i] = i[9:0];
		if (m_sort) begin
			for (int unsigned s = 0; s < n; s += len) begin
				len = (n - s > BLK) ? BLK : n - s;
				for (int unsigned i = s + 1; i < s + len; i++) begin
					v = m_order[i];
					j = i;
					while (j > s && ranks_lower(v, m_order[j-1])) begin
						m_order[j] = m_order[j-1];
						j--;
					end
					m_order[j] = v;
				end
			end
		end
		for (int i = 0; i < n; i++) m_inv[m_order[i]] = i[9:0];
		m_built_n = n;
		m_built = 1'b1;
	endfunction

	function automatic bdsp_pkg::result_t predict(bdsp_pkg::cmd_t c);
		bdsp_pkg::result_t r;
		logic [31:0] major, minor;
		r = '0;
		case (c.opcode)
			bdsp_pkg::OP_ADD: begin
				major = m_row ? c.row_index : c.column_index;
				minor = m_row ? c.column_index : c.row_index;
				if (major >= active_n()) r.status = bdsp_pkg::ST_RANGE;
				else begin
					if (m_cnt[major] != CNT_SAT) m_cnt[major]++;
					if (minor < m_least[major]) m_least[major] = minor;
				end
			end
			bdsp_pkg::OP_BUILD: build_order();
			bdsp_pkg::OP_READ: begin
				if (!m_built) r.status = bdsp_pkg::ST_NO_BUILD;
				else if (c.row_index >= m_built_n) r.status = bdsp_pkg::ST_RANGE;
				else begin
					r.perm_entry = m_order[c.row_index];
					r.inverse_entry = m_inv[c.row_index];
				end
			end
			default: wipe_counts();
		endcase
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy_at_edge) begin
				if (cmd_queue.size() > 0 && !driver_hold && $urandom_range(99) >= idle_pct) begin
					cmd <= cmd_queue.pop_front();
					start <= 1'b1;
				end else
					start <= 1'b0;
			end else if (!start && cmd_queue.size() > 0 && !driver_hold
					&& $urandom_range(99) >= idle_pct) begin
				cmd <= cmd_queue.pop_front();
				start <= 1'b1;
			end
		end
	end

	// acceptance and result check at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			busy_at_edge <= busy;
			if (start && !busy) begin
				result_queue.push_back(predict(cmd));
			end
			if (done) begin
				if (result_queue.size() == 0) begin
					$display("%0t unexpected result beat %p", $time, result);
					errors++;
				end else begin
					bdsp_pkg::result_t e;
					e = result_queue.pop_front();
					if (e.status !== result.status || e.perm_entry !== result.perm_entry
							|| e.inverse_entry !== result.inverse_entry) begin
						$display("%0t mismatch expected %p actual %p", $time, e, result);
						errors++;
					end
				end
			end
			if ((start && !busy) || done) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			bdsp_pkg::REG_DIM: m_dim = val[10:0];
			bdsp_pkg::REG_ROW: m_row = val[0];
			bdsp_pkg::REG_FIRST: m_first = val[0];
			default: m_sort = val[0];
		endcase
	endtask

	task automatic drain_all();
		do begin
			while (cmd_queue.size() > 0 || start || busy || result_queue.size() > 0)
				@(negedge clk);
			repeat (4) @(negedge clk);
		end while (cmd_queue.size() > 0 || start || busy || result_queue.size() > 0);
	endtask

	function automatic bdsp_pkg::cmd_t mk(logic [1:0] op, logic [31:0] r, logic [31:0] c);
		bdsp_pkg::cmd_t x;
		x.opcode = op; x.row_index = r; x.column_index = c;
		return x;
	endfunction

	// mostly in-range indices for adds and reads, with a few wild ones
	function automatic logic [31:0] pick_index(int unsigned n);
		int unsigned k;
		k = $urandom_range(99);
		if (k < 85 && n > 0) return $urandom_range(n - 1);
		if (k < 92) return n;
		return $urandom;
	endfunction

	task automatic random_phase(int items, int unsigned n);
		logic [31:0] major, minor;
		for (int i = 0; i < items; i++) begin
			case ($urandom_range(99)) inside
				[0:69]: begin
					major = pick_index(n);
					minor = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2047);
					cmd_queue.push_back(m_row ? mk(bdsp_pkg::OP_ADD, major, minor)
						: mk(bdsp_pkg::OP_ADD, minor, major));
				end
				[70:73]: cmd_queue.push_back(mk(bdsp_pkg::OP_BUILD, $urandom, $urandom));
				[74:97]: cmd_queue.push_back(mk(bdsp_pkg::OP_READ, pick_index(n), $urandom));
				default: cmd_queue.push_back(mk(bdsp_pkg::OP_CLEAR, $urandom, $urandom));
			endcase
		end
	endtask

	initial begin
		m_dim = 11'd1024; m_row = 1'b1; m_first = 1'b0; m_sort = 1'b1;
		wipe_counts();
		m_built = 1'b0; m_built_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: a read before build, extremes, clear, build on the reset setting
		cmd_queue.push_back(mk(bdsp_pkg::OP_READ, 0, 0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_ADD, 32'd1023, 32'hFFFF_FFFF));
		cmd_queue.push_back(mk(bdsp_pkg::OP_ADD, 32'd1023, 32'd0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_ADD, 32'd5, 32'd7));
		cmd_queue.push_back(mk(bdsp_pkg::OP_ADD, 32'd1024, 32'd7));
		cmd_queue.push_back(mk(bdsp_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		cmd_queue.push_back(mk(bdsp_pkg::OP_ADD, 32'd300, 32'd1));
		cmd_queue.push_back(mk(bdsp_pkg::OP_BUILD, 0, 0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_READ, 0, 0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_READ, 255, 0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_READ, 1023, 0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_READ, 1024, 0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_READ, 32'hFFFF_FFFF, 0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_CLEAR, 0, 0));
		cmd_queue.push_back(mk(bdsp_pkg::OP_ADD, 32'd3, 32'd3));
		cmd_queue.push_back(mk(bdsp_pkg::OP_READ, 5, 0));
		drain_all();

		// settings sweep; small dimensions keep builds short
		for (int ph = 0; ph < 9; ph++) begin
			logic [10:0] d;
			case (ph)
				0: d = 11'd0;
				1: d = 11'd1;
				2: d = 11'd2047;
				3: d = 11'd300;
				default: d = 11'($urandom_range(1, 40));
			endcase
			reg_write(bdsp_pkg::REG_DIM, (32'($urandom) & 32'hFFFF_F800) | {21'd0, d});
			reg_write(bdsp_pkg::REG_ROW, $urandom);
			reg_write(bdsp_pkg::REG_FIRST, (ph == 3) ? 32'd1 : $urandom);
			reg_write(bdsp_pkg::REG_SORT,
				(ph == 5) ? 32'd0 : ((ph == 6) ? 32'hFFFF_FFFE : $urandom));
			idle_pct = (ph == 4) ? 0 : 6;
			random_phase((ph < 3) ? 30 : 110, active_n());
			if (ph == 7) begin
				// sender holds off until everything outstanding has returned
				while (cmd_queue.size() > 40) @(negedge clk);
				driver_hold = 1'b1;
				@(negedge clk);
				while (start || busy || result_queue.size() > 0) @(negedge clk);
				driver_hold = 1'b0;
			end
			drain_all();
		end

		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/bdsp_pkg.sv
rtl/core/bdsp_cell.sv
rtl/core/bdsp_chain.sv
rtl/core/blocked_degree_sort_permutation.sv
tb/tb_blocked_degree_sort_permutation.sv
